[hw/rtl/lwcb_pkg.sv]
// ============================================================================
// lwcb_pkg: shared types and constants of the wipe crossfade blend
// Widths, reciprocal constants, register indexes and the records that pass
// between the pipeline sections.
// ============================================================================
package lwcb_pkg;

  localparam int COORD_BITS  = 10;
  localparam int CH_BITS     = 8;
  localparam int FULL_SCALE  = 255;

  // Front computation: progress * (size + fade) / 255.
  localparam int SUM_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS   = SUM_BITS + CH_BITS;
  localparam int FRONT_SHIFT = PROD_BITS + 8;
  localparam int RECIP_BITS  = COORD_BITS + 10;
  localparam logic [63:0] FRONT_RECIP =
    ((64'd1 << FRONT_SHIFT) + 64'd254) / 64'd255;

  // Signed position, signed distance and divider numerator.
  localparam int POS_BITS    = COORD_BITS + 2;
  localparam int DIST_BITS   = COORD_BITS + 3;
  localparam int MAG_BITS    = DIST_BITS - 1;
  localparam int NUM_BITS    = COORD_BITS + CH_BITS;

  // Divider: two quotient bits per stage.
  localparam int STEP_BITS   = 2;
  localparam int DIV_STAGES  = CH_BITS / STEP_BITS;

  // Channel mix: exact division of a 16-bit sum by 255.
  localparam int MIX_BITS        = 2 * CH_BITS;
  localparam int MIX_SHIFT       = 24;
  localparam int MIX_RECIP_BITS  = 17;
  localparam logic [MIX_RECIP_BITS-1:0] MIX_RECIP = 17'd65794;

  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_AXIS_SELECT       = 3'd0,
    REG_FORWARD_DIRECTION = 3'd1,
    REG_FADE_WIDTH        = 3'd2,
    REG_MATRIX_WIDTH      = 3'd3,
    REG_MATRIX_HEIGHT     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic                  axis_select;
    logic                  forward_direction;
    logic [COORD_BITS-1:0] fade_width;
    logic [COORD_BITS-1:0] matrix_width;
    logic [COORD_BITS-1:0] matrix_height;
  } cfg_t;

  typedef struct packed {
    logic [NUM_BITS-1:0]   num;
    logic                  sat;
    logic [COORD_BITS-1:0] fade;
    rgb_t                  old_rgb;
    rgb_t                  new_rgb;
  } div_req_t;

  typedef struct packed {
    logic [CH_BITS-1:0] weight;
    rgb_t               old_rgb;
    rgb_t               new_rgb;
  } mix_req_t;

endpackage

[hw/rtl/led_wipe_crossfade_blend.sv]
// ============================================================================
// led_wipe_crossfade_blend: soft-edged wipe crossfade for one LED
// Each accepted request passes the front, divider and mix sections in turn.
// Throughput is one request per cycle, set by the fully pipelined divider
// and mix stages; busy is never raised.
// Synchronous active-low reset clears the pipeline valid bits and loads the
// register defaults; the result strobe cannot be held off by the receiver.
// ============================================================================
module led_wipe_crossfade_blend (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [lwcb_pkg::CH_BITS-1:0]        in_progress,
  input  logic [lwcb_pkg::COORD_BITS-1:0]     in_pos_x,
  input  logic [lwcb_pkg::COORD_BITS-1:0]     in_pos_y,
  input  logic [lwcb_pkg::CH_BITS-1:0]        in_old_red,
  input  logic [lwcb_pkg::CH_BITS-1:0]        in_old_green,
  input  logic [lwcb_pkg::CH_BITS-1:0]        in_old_blue,
  input  logic [lwcb_pkg::CH_BITS-1:0]        in_new_red,
  input  logic [lwcb_pkg::CH_BITS-1:0]        in_new_green,
  input  logic [lwcb_pkg::CH_BITS-1:0]        in_new_blue,
  output logic                                out_valid,
  output logic [lwcb_pkg::CH_BITS-1:0]        out_red,
  output logic [lwcb_pkg::CH_BITS-1:0]        out_green,
  output logic [lwcb_pkg::CH_BITS-1:0]        out_blue,
  output logic [lwcb_pkg::CH_BITS-1:0]        out_blend_weight,
  input  logic                                cfg_we,
  input  logic [lwcb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [lwcb_pkg::COORD_BITS-1:0]     cfg_wdata
);

  lwcb_pkg::cfg_t     cfg_r;
  lwcb_pkg::cfg_t     cfg_nxt;
  lwcb_pkg::rgb_t     old_rgb;
  lwcb_pkg::rgb_t     new_rgb;
  lwcb_pkg::rgb_t     out_rgb;
  logic               div_valid;
  lwcb_pkg::div_req_t div_req;
  logic               mix_valid;
  lwcb_pkg::mix_req_t mix_req;
  logic               in_valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (lwcb_pkg::cfg_reg_t'(cfg_index))
        lwcb_pkg::REG_AXIS_SELECT:       cfg_nxt.axis_select       = cfg_wdata[0];
        lwcb_pkg::REG_FORWARD_DIRECTION: cfg_nxt.forward_direction = cfg_wdata[0];
        lwcb_pkg::REG_FADE_WIDTH:        cfg_nxt.fade_width        = cfg_wdata;
        lwcb_pkg::REG_MATRIX_WIDTH:      cfg_nxt.matrix_width      = cfg_wdata;
        lwcb_pkg::REG_MATRIX_HEIGHT:     cfg_nxt.matrix_height     = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axis_select       <= 1'b0;
      cfg_r.forward_direction <= 1'b1;
      cfg_r.fade_width        <= lwcb_pkg::COORD_BITS'(16);
      cfg_r.matrix_width      <= lwcb_pkg::COORD_BITS'(16);
      cfg_r.matrix_height     <= lwcb_pkg::COORD_BITS'(16);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  assign old_rgb.red   = in_old_red;
  assign old_rgb.green = in_old_green;
  assign old_rgb.blue  = in_old_blue;
  assign new_rgb.red   = in_new_red;
  assign new_rgb.green = in_new_green;
  assign new_rgb.blue  = in_new_blue;

  lwcb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .cfg       (cfg_r),
    .progress  (in_progress),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .old_rgb   (old_rgb),
    .new_rgb   (new_rgb),
    .div_valid (div_valid),
    .div_req   (div_req)
  );

  lwcb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_valid (div_valid),
    .div_req   (div_req),
    .mix_valid (mix_valid),
    .mix_req   (mix_req)
  );

  lwcb_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .mix_valid  (mix_valid),
    .mix_req    (mix_req),
    .out_valid  (out_valid),
    .out_rgb    (out_rgb),
    .out_weight (out_blend_weight)
  );

  assign out_red   = out_rgb.red;
  assign out_green = out_rgb.green;
  assign out_blue  = out_rgb.blue;

endmodule

[hw/rtl/lwcb_front.sv]
// ============================================================================
// lwcb_front: wipe front, position and scaled distance
// Three register stages: span product, front by reciprocal multiply, and the
// distance scaled by 255 with the saturation flag.
// ============================================================================
module lwcb_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  lwcb_pkg::cfg_t                  cfg,
  input  logic [lwcb_pkg::CH_BITS-1:0]    progress,
  input  logic [lwcb_pkg::COORD_BITS-1:0] pos_x,
  input  logic [lwcb_pkg::COORD_BITS-1:0] pos_y,
  input  lwcb_pkg::rgb_t                  old_rgb,
  input  lwcb_pkg::rgb_t                  new_rgb,
  output logic                            div_valid,
  output lwcb_pkg::div_req_t              div_req
);

  localparam int FPROD_BITS = lwcb_pkg::PROD_BITS + lwcb_pkg::RECIP_BITS;

  logic [lwcb_pkg::COORD_BITS-1:0] size;
  logic [lwcb_pkg::COORD_BITS-1:0] coord;
  logic [lwcb_pkg::COORD_BITS-1:0] fade;
  logic [lwcb_pkg::SUM_BITS-1:0]   span;
  logic [lwcb_pkg::PROD_BITS-1:0]  prod_nxt;
  logic [lwcb_pkg::POS_BITS-1:0]   pos_nxt;

  logic                            v1_r;
  logic [lwcb_pkg::PROD_BITS-1:0]  prod1_r;
  logic [lwcb_pkg::POS_BITS-1:0]   pos1_r;
  logic [lwcb_pkg::COORD_BITS-1:0] fade1_r;
  lwcb_pkg::rgb_t                  old1_r;
  lwcb_pkg::rgb_t                  new1_r;

  logic [FPROD_BITS-1:0]           fprod;
  logic [lwcb_pkg::SUM_BITS-1:0]   front_nxt;

  logic                            v2_r;
  logic [lwcb_pkg::SUM_BITS-1:0]   front2_r;
  logic [lwcb_pkg::POS_BITS-1:0]   pos2_r;
  logic [lwcb_pkg::COORD_BITS-1:0] fade2_r;
  lwcb_pkg::rgb_t                  old2_r;
  lwcb_pkg::rgb_t                  new2_r;

  logic [lwcb_pkg::DIST_BITS-1:0]  gap;
  logic                            dist_neg;
  logic [lwcb_pkg::MAG_BITS-1:0]   mag;
  logic [lwcb_pkg::MAG_BITS+7:0]   scaled;
  lwcb_pkg::div_req_t              req_nxt;

  logic                            v3_r;
  lwcb_pkg::div_req_t              req3_r;

  always_comb begin
    size  = cfg.axis_select ? cfg.matrix_width : cfg.matrix_height;
    coord = cfg.axis_select ? pos_x : pos_y;
    fade  = (cfg.fade_width == '0) ? lwcb_pkg::COORD_BITS'(1) : cfg.fade_width;
    span  = lwcb_pkg::SUM_BITS'(size) + lwcb_pkg::SUM_BITS'(fade);
    prod_nxt = lwcb_pkg::PROD_BITS'(progress) * lwcb_pkg::PROD_BITS'(span);
    if (cfg.forward_direction) begin
      pos_nxt = lwcb_pkg::POS_BITS'(coord);
    end else begin
      pos_nxt = lwcb_pkg::POS_BITS'(size) - lwcb_pkg::POS_BITS'(coord);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    prod1_r <= prod_nxt;
    pos1_r  <= pos_nxt;
    fade1_r <= fade;
    old1_r  <= old_rgb;
    new1_r  <= new_rgb;
  end

  always_comb begin
    fprod = FPROD_BITS'(prod1_r) *
            FPROD_BITS'(lwcb_pkg::FRONT_RECIP[lwcb_pkg::RECIP_BITS-1:0]);
    front_nxt = fprod[lwcb_pkg::FRONT_SHIFT +: lwcb_pkg::SUM_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    front2_r <= front_nxt;
    pos2_r   <= pos1_r;
    fade2_r  <= fade1_r;
    old2_r   <= old1_r;
    new2_r   <= new1_r;
  end

  // A position at or beyond the front gives a zero numerator; a distance of
  // at least one fade width saturates the weight.
  always_comb begin
    gap = lwcb_pkg::DIST_BITS'(front2_r) -
          {{(lwcb_pkg::DIST_BITS - lwcb_pkg::POS_BITS){pos2_r[lwcb_pkg::POS_BITS-1]}},
           pos2_r};
    dist_neg = gap[lwcb_pkg::DIST_BITS-1];
    mag      = gap[lwcb_pkg::MAG_BITS-1:0];
    scaled   = {mag, 8'b0} - (lwcb_pkg::MAG_BITS + 8)'(mag);
    req_nxt.sat  = !dist_neg && (mag >= lwcb_pkg::MAG_BITS'(fade2_r));
    req_nxt.num  = (dist_neg || req_nxt.sat) ? '0 : scaled[lwcb_pkg::NUM_BITS-1:0];
    req_nxt.fade    = fade2_r;
    req_nxt.old_rgb = old2_r;
    req_nxt.new_rgb = new2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    req3_r <= req_nxt;
  end

  assign div_valid = v3_r;
  assign div_req   = req3_r;

endmodule

[hw/rtl/lwcb_div.sv]
// ============================================================================
// lwcb_div: pipelined restoring divider for the blend weight
// Two quotient bits per stage; the saturation flag forces full weight.
// ============================================================================
module lwcb_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 div_valid,
  input  lwcb_pkg::div_req_t   div_req,
  output logic                 mix_valid,
  output lwcb_pkg::mix_req_t   mix_req
);

  localparam int LAST = lwcb_pkg::DIV_STAGES - 1;

  logic                          v_r   [lwcb_pkg::DIV_STAGES];
  lwcb_pkg::div_req_t            req_r [lwcb_pkg::DIV_STAGES];
  logic [lwcb_pkg::CH_BITS-1:0]  q_r   [lwcb_pkg::DIV_STAGES];

  lwcb_pkg::div_req_t            req_nxt [lwcb_pkg::DIV_STAGES];
  logic [lwcb_pkg::CH_BITS-1:0]  q_nxt   [lwcb_pkg::DIV_STAGES];

  always_comb begin
    logic [lwcb_pkg::NUM_BITS-1:0] trial;
    int                            k;
    for (int s = 0; s < lwcb_pkg::DIV_STAGES; s++) begin
      if (s == 0) begin
        req_nxt[s] = div_req;
        q_nxt[s]   = '0;
      end else begin
        req_nxt[s] = req_r[s-1];
        q_nxt[s]   = q_r[s-1];
      end
      for (int b = 0; b < lwcb_pkg::STEP_BITS; b++) begin
        k     = lwcb_pkg::CH_BITS - 1 - s * lwcb_pkg::STEP_BITS - b;
        trial = lwcb_pkg::NUM_BITS'(req_nxt[s].fade) << k;
        if (req_nxt[s].num >= trial) begin
          req_nxt[s].num = req_nxt[s].num - trial;
          q_nxt[s][k]    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < lwcb_pkg::DIV_STAGES; s++) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (s == 0) begin
        v_r[s] <= div_valid;
      end else begin
        v_r[s] <= v_r[s-1];
      end
      req_r[s] <= req_nxt[s];
      q_r[s]   <= q_nxt[s];
    end
  end

  always_comb begin
    mix_valid       = v_r[LAST];
    mix_req.weight  = req_r[LAST].sat ? lwcb_pkg::CH_BITS'(lwcb_pkg::FULL_SCALE)
                                      : q_r[LAST];
    mix_req.old_rgb = req_r[LAST].old_rgb;
    mix_req.new_rgb = req_r[LAST].new_rgb;
  end

endmodule

[hw/rtl/lwcb_mix.sv]
// ============================================================================
// lwcb_mix: per-channel colour mix
// Weighted sum of old and new colour, then an exact division by 255 through
// a reciprocal multiply. Two register stages.
// ============================================================================
module lwcb_mix (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         mix_valid,
  input  lwcb_pkg::mix_req_t           mix_req,
  output logic                         out_valid,
  output lwcb_pkg::rgb_t               out_rgb,
  output logic [lwcb_pkg::CH_BITS-1:0] out_weight
);

  localparam int MPROD_BITS = lwcb_pkg::MIX_BITS + lwcb_pkg::MIX_RECIP_BITS;

  logic [lwcb_pkg::CH_BITS-1:0]  inv_w;
  logic [lwcb_pkg::MIX_BITS-1:0] acc_nxt [3];
  logic [lwcb_pkg::CH_BITS-1:0]  old_ch  [3];
  logic [lwcb_pkg::CH_BITS-1:0]  new_ch  [3];

  logic                          v1_r;
  logic [lwcb_pkg::MIX_BITS-1:0] acc_r [3];
  logic [lwcb_pkg::CH_BITS-1:0]  w1_r;

  logic [MPROD_BITS-1:0]         mprod  [3];
  logic [lwcb_pkg::CH_BITS-1:0]  ch_nxt [3];

  logic                          v2_r;
  logic [lwcb_pkg::CH_BITS-1:0]  ch_r [3];
  logic [lwcb_pkg::CH_BITS-1:0]  w2_r;

  always_comb begin
    inv_w = lwcb_pkg::CH_BITS'(lwcb_pkg::FULL_SCALE) - mix_req.weight;
    old_ch[0] = mix_req.old_rgb.red;
    old_ch[1] = mix_req.old_rgb.green;
    old_ch[2] = mix_req.old_rgb.blue;
    new_ch[0] = mix_req.new_rgb.red;
    new_ch[1] = mix_req.new_rgb.green;
    new_ch[2] = mix_req.new_rgb.blue;
    for (int c = 0; c < 3; c++) begin
      acc_nxt[c] = lwcb_pkg::MIX_BITS'(old_ch[c]) * lwcb_pkg::MIX_BITS'(inv_w) +
                   lwcb_pkg::MIX_BITS'(new_ch[c]) * lwcb_pkg::MIX_BITS'(mix_req.weight);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= mix_valid;
    end
    for (int c = 0; c < 3; c++) begin
      acc_r[c] <= acc_nxt[c];
    end
    w1_r <= mix_req.weight;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mprod[c]  = MPROD_BITS'(acc_r[c]) * MPROD_BITS'(lwcb_pkg::MIX_RECIP);
      ch_nxt[c] = mprod[c][lwcb_pkg::MIX_SHIFT +: lwcb_pkg::CH_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    for (int c = 0; c < 3; c++) begin
      ch_r[c] <= ch_nxt[c];
    end
    w2_r <= w1_r;
  end

  assign out_valid     = v2_r;
  assign out_rgb.red   = ch_r[0];
  assign out_rgb.green = ch_r[1];
  assign out_rgb.blue  = ch_r[2];
  assign out_weight    = w2_r;

endmodule

[tb/tb_led_wipe_crossfade_blend.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_led_wipe_crossfade_blend: self-checking bench for the wipe crossfade blend
// Drives LED requests through the command port, predicts the blended colour
// and weight of each accepted request, and compares every result strobe in
// order. The wipe registers are changed between phases while the pipe is empty.
// ============================================================================
module tb_led_wipe_crossfade_blend;

  typedef struct packed {
    logic [lwcb_pkg::CH_BITS-1:0]    progress;
    logic [lwcb_pkg::COORD_BITS-1:0] pos_x;
    logic [lwcb_pkg::COORD_BITS-1:0] pos_y;
    lwcb_pkg::rgb_t                  old_rgb;
    lwcb_pkg::rgb_t                  new_rgb;
  } led_req_t;

  typedef struct packed {
    lwcb_pkg::rgb_t               color;
    logic [lwcb_pkg::CH_BITS-1:0] weight;
  } led_blend_t;

  class blend_scoreboard;
    lwcb_pkg::cfg_t wipe_cfg = '{axis_select: 1'b0, forward_direction: 1'b1,
                                 fade_width: 10'd16, matrix_width: 10'd16,
                                 matrix_height: 10'd16};
    led_blend_t     blends_due[$];
    int             errors = 0;

    function automatic logic [lwcb_pkg::CH_BITS-1:0] mix_channel(
        logic [lwcb_pkg::CH_BITS-1:0] old_c, logic [lwcb_pkg::CH_BITS-1:0] new_c,
        int unsigned w);
      int unsigned acc;
      acc = (old_c * (lwcb_pkg::FULL_SCALE - w) + new_c * w) / lwcb_pkg::FULL_SCALE;
      return acc[lwcb_pkg::CH_BITS-1:0];
    endfunction

    function automatic led_blend_t wipe_blend(led_req_t r);
      led_blend_t  b;
      int          size, coord, fade, front, pos, q;
      int unsigned w;
      size  = wipe_cfg.axis_select ? int'(wipe_cfg.matrix_width) : int'(wipe_cfg.matrix_height);
      coord = wipe_cfg.axis_select ? int'(r.pos_x) : int'(r.pos_y);
      fade  = (wipe_cfg.fade_width == 0) ? 1 : int'(wipe_cfg.fade_width);
      front = (int'(r.progress) * (size + fade)) / lwcb_pkg::FULL_SCALE;
      pos   = wipe_cfg.forward_direction ? coord : size - coord;
      if (pos > front) begin
        w = 0;
      end else begin
        q = ((front - pos) * lwcb_pkg::FULL_SCALE) / fade;
        w = (q > lwcb_pkg::FULL_SCALE) ? lwcb_pkg::FULL_SCALE : q;
      end
      b.color.red   = mix_channel(r.old_rgb.red, r.new_rgb.red, w);
      b.color.green = mix_channel(r.old_rgb.green, r.new_rgb.green, w);
      b.color.blue  = mix_channel(r.old_rgb.blue, r.new_rgb.blue, w);
      b.weight      = w[lwcb_pkg::CH_BITS-1:0];
      return b;
    endfunction

    function void note_request(led_req_t r);
      blends_due.push_back(wipe_blend(r));
    endfunction

    function int pending();
      return blends_due.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(lwcb_pkg::rgb_t color, logic [lwcb_pkg::CH_BITS-1:0] weight);
      led_blend_t want;
      if (blends_due.size() == 0) begin
        report_mismatch("unrequested result", 1, 0);
      end else begin
        want = blends_due.pop_front();
        if (color.red !== want.color.red)
          report_mismatch("out_red", int'(color.red), int'(want.color.red));
        if (color.green !== want.color.green)
          report_mismatch("out_green", int'(color.green), int'(want.color.green));
        if (color.blue !== want.color.blue)
          report_mismatch("out_blue", int'(color.blue), int'(want.color.blue));
        if (weight !== want.weight)
          report_mismatch("out_blend_weight", int'(weight), int'(want.weight));
      end
    endtask
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic [lwcb_pkg::CH_BITS-1:0]      in_progress;
  logic [lwcb_pkg::COORD_BITS-1:0]   in_pos_x;
  logic [lwcb_pkg::COORD_BITS-1:0]   in_pos_y;
  logic [lwcb_pkg::CH_BITS-1:0]      in_old_red, in_old_green, in_old_blue;
  logic [lwcb_pkg::CH_BITS-1:0]      in_new_red, in_new_green, in_new_blue;
  logic                              out_valid;
  logic [lwcb_pkg::CH_BITS-1:0]      out_red, out_green, out_blue, out_blend_weight;
  logic                              cfg_we;
  logic [lwcb_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [lwcb_pkg::COORD_BITS-1:0]   cfg_wdata;

  blend_scoreboard sb = new();
  int              sent = 0;

  led_wipe_crossfade_blend dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_progress      (in_progress),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_old_red       (in_old_red),
    .in_old_green     (in_old_green),
    .in_old_blue      (in_old_blue),
    .in_new_red       (in_new_red),
    .in_new_green     (in_new_green),
    .in_new_blue      (in_new_blue),
    .out_valid        (out_valid),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_blend_weight (out_blend_weight),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check_result('{red: out_red, green: out_green, blue: out_blue}, out_blend_weight);
  end

  function automatic led_req_t led_req(int progress, int x, int y, int old_c, int new_c);
    led_req_t r;
    r.progress = lwcb_pkg::CH_BITS'(progress);
    r.pos_x    = lwcb_pkg::COORD_BITS'(x);
    r.pos_y    = lwcb_pkg::COORD_BITS'(y);
    r.old_rgb  = (3 * lwcb_pkg::CH_BITS)'(old_c);
    r.new_rgb  = (3 * lwcb_pkg::CH_BITS)'(new_c);
    return r;
  endfunction

  function automatic logic [lwcb_pkg::CH_BITS-1:0] pick_channel();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    return lwcb_pkg::CH_BITS'($urandom_range(255, 0));
  endfunction

  function automatic led_req_t random_req(lwcb_pkg::cfg_t c);
    led_req_t r;
    int       extent, hi, coord;
    extent = (c.axis_select ? int'(c.matrix_width) : int'(c.matrix_height))
             + ((c.fade_width == 0) ? 1 : int'(c.fade_width));
    hi     = (extent + 2 > 1022) ? 1022 : extent + 2;
    coord  = ($urandom_range(99) < 80) ? $urandom_range(hi, 0) : $urandom_range(1022, 0);
    r.progress = lwcb_pkg::CH_BITS'($urandom_range(255, 0));
    r.pos_x    = lwcb_pkg::COORD_BITS'(c.axis_select ? coord : int'($urandom_range(1022, 0)));
    r.pos_y    = lwcb_pkg::COORD_BITS'(c.axis_select ? int'($urandom_range(1022, 0)) : coord);
    r.old_rgb  = '{red: pick_channel(), green: pick_channel(), blue: pick_channel()};
    r.new_rgb  = '{red: pick_channel(), green: pick_channel(), blue: pick_channel()};
    return r;
  endfunction

  function automatic logic [lwcb_pkg::COORD_BITS-1:0] random_extent();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return lwcb_pkg::COORD_BITS'($urandom_range(40, 1));
    if (roll < 90) return lwcb_pkg::COORD_BITS'($urandom_range(1023, 1));
    return (roll < 95) ? 10'd1 : 10'd1023;
  endfunction

  task automatic issue(led_req_t r);
    start        <= 1'b1;
    in_progress  <= r.progress;
    in_pos_x     <= r.pos_x;
    in_pos_y     <= r.pos_y;
    in_old_red   <= r.old_rgb.red;
    in_old_green <= r.old_rgb.green;
    in_old_blue  <= r.old_rgb.blue;
    in_new_red   <= r.new_rgb.red;
    in_new_green <= r.new_rgb.green;
    in_new_blue  <= r.new_rgb.blue;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(r);
    sent++;
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic put_reg(lwcb_pkg::cfg_reg_t idx, logic [lwcb_pkg::COORD_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic set_wipe(lwcb_pkg::cfg_t c);
    put_reg(lwcb_pkg::REG_AXIS_SELECT, lwcb_pkg::COORD_BITS'(c.axis_select));
    put_reg(lwcb_pkg::REG_FORWARD_DIRECTION, lwcb_pkg::COORD_BITS'(c.forward_direction));
    put_reg(lwcb_pkg::REG_FADE_WIDTH, c.fade_width);
    put_reg(lwcb_pkg::REG_MATRIX_WIDTH, c.matrix_width);
    put_reg(lwcb_pkg::REG_MATRIX_HEIGHT, c.matrix_height);
    cfg_we <= 1'b0;
    sb.wipe_cfg = c;
  endtask

  task automatic random_phase(int count);
    lwcb_pkg::cfg_t c;
    c.axis_select       = 1'($urandom_range(1, 0));
    c.forward_direction = 1'($urandom_range(1, 0));
    c.fade_width        = random_extent();
    c.matrix_width      = random_extent();
    c.matrix_height     = random_extent();
    drain();
    set_wipe(c);
    repeat (count) begin
      while ((sent < 500 || sent > 720) && $urandom_range(99) < 21)
        hold_off(1);
      issue(random_req(c));
    end
  endtask

  initial begin
    start     <= 1'b0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= lwcb_pkg::REG_AXIS_SELECT;
    cfg_wdata <= '0;
    in_progress <= '0;
    in_pos_x  <= '0;
    in_pos_y  <= '0;
    {in_old_red, in_old_green, in_old_blue} <= '0;
    {in_new_red, in_new_green, in_new_blue} <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: y axis, forward, 16 wide edge over 16 rows.
    issue(led_req(0, 0, 0, 24'hFFFFFF, 24'h000000));
    issue(led_req(255, 0, 0, 24'hFFFFFF, 24'h000000));
    issue(led_req(128, 3, 16, 24'h123456, 24'hABCDEF));
    issue(led_req(128, 0, 8, 24'h000000, 24'hFFFFFF));
    issue(led_req(128, 1022, 17, 24'hFF00FF, 24'h00FF00));
    issue(led_req(255, 1022, 1022, 24'h0F0F0F, 24'hF0F0F0));
    issue(led_req(200, 511, 10, 24'hFF8001, 24'h017FFE));
    issue(led_req(255, 513, 31, 24'hFFFFFF, 24'hFFFFFF));

    // Zero fade and zero size, reverse direction along x.
    drain();
    set_wipe('{axis_select: 1'b1, forward_direction: 1'b0, fade_width: 10'd0,
               matrix_width: 10'd0, matrix_height: 10'd1023});
    issue(led_req(0, 0, 0, 24'h00FF00, 24'hFF00FF));
    issue(led_req(255, 0, 1022, 24'h00FF00, 24'hFF00FF));
    issue(led_req(0, 1022, 0, 24'h808080, 24'h7F7F7F));
    issue(led_req(100, 5, 5, 24'hFFFFFF, 24'h000000));

    // Largest edge and extent, reverse along y.
    drain();
    set_wipe('{axis_select: 1'b0, forward_direction: 1'b0, fade_width: 10'd1023,
               matrix_width: 10'd5, matrix_height: 10'd1023});
    issue(led_req(255, 0, 0, 24'hFFFFFF, 24'h000000));
    issue(led_req(0, 1022, 1022, 24'h000000, 24'hFFFFFF));
    issue(led_req(127, 700, 512, 24'hA5A5A5, 24'h5A5A5A));
    issue(led_req(255, 3, 1022, 24'hFFFFFF, 24'h000000));

    // Narrowest edge on a one-column matrix, forward along x.
    drain();
    set_wipe('{axis_select: 1'b1, forward_direction: 1'b1, fade_width: 10'd1,
               matrix_width: 10'd1, matrix_height: 10'd0});
    issue(led_req(255, 0, 0, 24'h000000, 24'hFFFFFF));
    issue(led_req(128, 1, 0, 24'h000000, 24'hFFFFFF));
    issue(led_req(255, 2, 1022, 24'hFFFFFF, 24'h000000));
    issue(led_req(127, 0, 7, 24'h102030, 24'hF0E0D0));

    repeat (10) random_phase(113);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lwcb_pkg.sv
hw/rtl/lwcb_front.sv
hw/rtl/lwcb_div.sv
hw/rtl/lwcb_mix.sv
hw/rtl/led_wipe_crossfade_blend.sv
tb/tb_led_wipe_crossfade_blend.sv
